// File: hdl/mnps_pkg.sv
// ----------------------------------------------------------------------------
// mnps_pkg: shared types and constants of the neighbor pair search
// Request and result layouts, register indexes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none
package mnps_pkg;

	localparam int MAX_ATOMS_DEF = 64;
	localparam int COORD_W       = 32;
	localparam int KIND_W        = 8;
	localparam int IDX_W         = 6;
	localparam int LEN_W         = 31;
	localparam int RAM_W         = 3 * COORD_W + KIND_W;

	localparam logic [LEN_W-1:0] BOX_LEN_RST = LEN_W'(65536);
	localparam logic [LEN_W-1:0] CUTOFF_RST  = '0;

	typedef enum logic [1:0] {
		REG_BOX_X  = 2'd0,
		REG_BOX_Y  = 2'd1,
		REG_BOX_Z  = 2'd2,
		REG_CUTOFF = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                      first_atom;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [KIND_W-1:0]         atom_kind;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]          earlier_index;
		logic [IDX_W-1:0]          new_index;
		logic [KIND_W-1:0]         earlier_kind;
		logic signed [COORD_W-1:0] vec_x;
		logic signed [COORD_W-1:0] vec_y;
		logic signed [COORD_W-1:0] vec_z;
		logic [LEN_W-1:0]          distance;
		logic                      last_pair;
		logic                      overflow;
	} result_t;

endpackage
`default_nettype wire

// File: hdl/mnps_ram.sv
// ----------------------------------------------------------------------------
// mnps_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module mnps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/min_image_neighbor_pair_search.sv
// ----------------------------------------------------------------------------
// min_image_neighbor_pair_search: minimum-image neighbor pairs in a periodic box
// Stores arriving atoms and reports every earlier atom within the cutoff.
// ----------------------------------------------------------------------------
// An atom request is taken when start is high and busy is low; busy then stays
// high until the atom is compared with all n stored atoms and stored itself.
// Each comparison runs a bit-serial remainder unit of 33 steps per axis (an axis
// with zero box length skips them), and every pair inside the cutoff adds 32
// square root steps and an emit state.
// Results appear on result for one cycle with done high and cannot be stalled;
// the last pair of an atom is marked by last_pair. A request arriving with the
// store full gives one result with overflow and last_pair set and no busy time.
`default_nettype none
module min_image_neighbor_pair_search #(
	parameter int MAX_ATOMS = mnps_pkg::MAX_ATOMS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire mnps_pkg::in_item_t item,
	output logic                   busy,
	output logic                   done,
	output mnps_pkg::result_t      result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	import mnps_pkg::*;

	localparam int AW    = $clog2(MAX_ATOMS);
	localparam int CNT_W = $clog2(MAX_ATOMS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_CUT, S_CUT2, S_RD, S_RDW, S_DIFF, S_DIV, S_FIX,
		S_SQ, S_ACC, S_CMP, S_SQRT, S_EMIT, S_NEXT, S_STORE
	} state_t;

	// configuration registers
	logic [LEN_W-1:0] box_x_q, box_y_q, box_z_q, cutoff_q;
	reg_idx_t         widx;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q  <= BOX_LEN_RST;
			box_y_q  <= BOX_LEN_RST;
			box_z_q  <= BOX_LEN_RST;
			cutoff_q <= CUTOFF_RST;
		end else if (psel && penable && pwrite) begin
			unique case (widx)
				REG_BOX_X:  box_x_q  <= pwdata[LEN_W-1:0];
				REG_BOX_Y:  box_y_q  <= pwdata[LEN_W-1:0];
				REG_BOX_Z:  box_z_q  <= pwdata[LEN_W-1:0];
				REG_CUTOFF: cutoff_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_BOX_X:  prdata = {1'b0, box_x_q};
			REG_BOX_Y:  prdata = {1'b0, box_y_q};
			REG_BOX_Z:  prdata = {1'b0, box_z_q};
			REG_CUTOFF: prdata = {1'b0, cutoff_q};
			default:    prdata = '0;
		endcase
	end

	// sequencer and shared datapath state
	state_t               state_q;
	in_item_t             item_q;
	logic [CNT_W-1:0]     cnt_q, nidx_q, i_q;
	logic [1:0]           axis_q;
	logic [63:0]          cut_sq_q, acc_q, prod_q;
	logic                 sqsat_q;
	logic signed [32:0]   d_q;
	logic                 neg_q;
	logic [32:0]          mag_q, sqm_q;
	logic [LEN_W-1:0]     len_q, rem_q;
	logic [5:0]           dcnt_q;
	logic [COORD_W-1:0]   vx_q, vy_q, vz_q;
	logic [63:0]          sx_q, sres_q, sbit_q;
	logic [4:0]           scnt_q;
	result_t              pend_q;
	logic                 pend_v_q;

	// memory of stored atoms
	logic [RAM_W-1:0] rdata, wdata;
	logic             ram_we;
	logic [AW-1:0]    waddr, raddr;

	assign ram_we = (state_q == S_STORE);
	assign waddr  = nidx_q[AW-1:0];
	assign raddr  = i_q[AW-1:0];
	assign wdata  = {item_q.pos_x, item_q.pos_y, item_q.pos_z, item_q.atom_kind};

	mnps_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_ATOMS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// axis selection
	logic [COORD_W-1:0] p_sel, s_sel;
	logic [LEN_W-1:0]   l_sel;
	logic signed [32:0] d_now;

	always_comb begin
		unique case (axis_q)
			2'd0:    begin p_sel = item_q.pos_x; s_sel = rdata[RAM_W-1 -: COORD_W];
				l_sel = box_x_q; end
			2'd1:    begin p_sel = item_q.pos_y; s_sel = rdata[RAM_W-COORD_W-1 -: COORD_W];
				l_sel = box_y_q; end
			default: begin p_sel = item_q.pos_z; s_sel = rdata[KIND_W +: COORD_W];
				l_sel = box_z_q; end
		endcase
	end

	assign d_now = $signed({p_sel[COORD_W-1], p_sel}) - $signed({s_sel[COORD_W-1], s_sel});

	// remainder step
	logic [31:0] div_t;
	logic        div_ge;
	assign div_t  = {rem_q, mag_q[32]};
	assign div_ge = div_t >= {1'b0, len_q};

	// wrap fix-up
	logic             fix_hi, fix_neg;
	logic [LEN_W-1:0] fix_m;
	logic [31:0]      fix_w, clamp_d;
	assign fix_hi  = {rem_q, 1'b0} >= {1'b0, len_q};
	assign fix_m   = fix_hi ? (len_q - rem_q) : rem_q;
	assign fix_neg = neg_q ^ fix_hi;
	assign fix_w   = fix_neg ? (32'd0 - {1'b0, fix_m}) : {1'b0, fix_m};
	assign clamp_d = (d_q[32] != d_q[31]) ? (d_q[32] ? 32'h8000_0000 : 32'h7fff_ffff)
		: d_q[31:0];

	// shared multiplier
	logic [31:0] mul_a;
	assign mul_a = (state_q == S_CUT) ? {1'b0, cutoff_q} : sqm_q[31:0];

	// saturating accumulate
	logic [64:0] acc_sum;
	assign acc_sum = {1'b0, acc_q} + {1'b0, prod_q};

	// square root step
	logic [63:0] sq_t;
	assign sq_t = sres_q + sbit_q;

	// index fields
	logic [CNT_W+IDX_W-1:0] i_ext, n_ext;
	assign i_ext = {{IDX_W{1'b0}}, i_q};
	assign n_ext = {{IDX_W{1'b0}}, nidx_q};

	logic [CNT_W-1:0] eff_cnt;
	assign eff_cnt = item.first_atom ? '0 : cnt_q;

	result_t new_pair, ovf_res, last_res;
	always_comb begin
		new_pair               = '0;
		new_pair.earlier_index = i_ext[IDX_W-1:0];
		new_pair.new_index     = n_ext[IDX_W-1:0];
		new_pair.earlier_kind  = rdata[KIND_W-1:0];
		new_pair.vec_x         = vx_q;
		new_pair.vec_y         = vy_q;
		new_pair.vec_z         = vz_q;
		new_pair.distance      = sres_q[LEN_W-1:0];
		ovf_res                = '0;
		ovf_res.last_pair      = 1'b1;
		ovf_res.overflow       = 1'b1;
		last_res               = pend_q;
		last_res.last_pair     = 1'b1;
	end

	// result strobe for the next cycle
	logic done_d;
	assign done_d = (state_q == S_IDLE && start && eff_cnt >= CNT_W'(MAX_ATOMS))
		|| ((state_q == S_EMIT || state_q == S_STORE) && pend_v_q);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			done     <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			done <= done_d;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						item_q <= item;
						if (eff_cnt >= CNT_W'(MAX_ATOMS)) begin
							result <= ovf_res;
						end else begin
							nidx_q  <= eff_cnt;
							state_q <= S_CUT;
						end
					end
				end
				S_CUT: state_q <= S_CUT2;
				S_CUT2: begin
					cut_sq_q <= prod_q;
					i_q      <= '0;
					state_q  <= (nidx_q == '0) ? S_STORE : S_RD;
				end
				S_RD: state_q <= S_RDW;
				S_RDW: begin
					acc_q   <= '0;
					axis_q  <= 2'd0;
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					d_q    <= d_now;
					neg_q  <= d_now[32];
					mag_q  <= d_now[32] ? (33'd0 - 33'(d_now)) : 33'(d_now);
					len_q  <= l_sel;
					rem_q  <= '0;
					dcnt_q <= '0;
					state_q <= (l_sel == '0) ? S_FIX : S_DIV;
				end
				S_DIV: begin
					rem_q  <= div_ge ? LEN_W'(div_t - {1'b0, len_q}) : div_t[LEN_W-1:0];
					mag_q  <= {mag_q[31:0], 1'b0};
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd32) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					// zero box length: raw difference, clamped for output only
					if (len_q == '0) begin
						sqm_q <= mag_q;
						unique case (axis_q)
							2'd0:    vx_q <= clamp_d;
							2'd1:    vy_q <= clamp_d;
							default: vz_q <= clamp_d;
						endcase
					end else begin
						sqm_q <= {2'b0, fix_m};
						unique case (axis_q)
							2'd0:    vx_q <= fix_w;
							2'd1:    vy_q <= fix_w;
							default: vz_q <= fix_w;
						endcase
					end
					state_q <= S_SQ;
				end
				S_SQ: begin
					sqsat_q <= sqm_q[32];
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= (acc_sum[64] || sqsat_q) ? '1 : acc_sum[63:0];
					if (axis_q == 2'd2) begin
						state_q <= S_CMP;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_DIFF;
					end
				end
				S_CMP: begin
					sx_q   <= acc_q;
					sres_q <= '0;
					sbit_q <= 64'h4000_0000_0000_0000;
					scnt_q <= '0;
					state_q <= (acc_q < cut_sq_q) ? S_SQRT : S_NEXT;
				end
				S_SQRT: begin
					if (sx_q >= sq_t) begin
						sx_q   <= sx_q - sq_t;
						sres_q <= (sres_q >> 1) + sbit_q;
					end else begin
						sres_q <= sres_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
					scnt_q <= scnt_q + 5'd1;
					if (scnt_q == 5'd31) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// hold one pair back so the final one can carry last_pair
					if (pend_v_q) begin
						result <= pend_q;
					end
					pend_q   <= new_pair;
					pend_v_q <= 1'b1;
					state_q  <= S_NEXT;
				end
				S_NEXT: begin
					if (i_q + CNT_W'(1) == nidx_q) begin
						state_q <= S_STORE;
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_RD;
					end
				end
				S_STORE: begin
					if (pend_v_q) begin
						result <= last_res;
					end
					pend_v_q <= 1'b0;
					cnt_q    <= nidx_q + CNT_W'(1);
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.overflow |-> result.last_pair)
		else $error("overflow result without last_pair");

	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !pend_v_q)
		else $error("pair left pending while idle");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ATOMS))
		else $error("atom count beyond capacity");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !item.first_atom && cnt_q == CNT_W'(MAX_ATOMS)
		|=> done && result.overflow && !busy)
		else $error("full store did not flag overflow");

	a_store_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STORE |=> !busy)
		else $error("store did not end the request");

endmodule
`default_nettype wire
